### rtl/core/prad_pkg.sv
// ----------------------------------------------------------------------------
// prad_pkg: shared types and constants of the priority region decoder
// Region register layout, access and kind codes, the stage payloads that
// travel down the pipeline, and the pairwise winner function.
// ----------------------------------------------------------------------------
package prad_pkg;

   // Design defaults
   localparam int ADDR_BITS_DEFAULT   = 24;
   localparam int NUM_REGIONS_DEFAULT = 8;
   localparam int PRIO_BITS_DEFAULT   = 4;

   // Fixed sizes of the register file and fields
   localparam int MAX_REGIONS  = 8;
   localparam int REGION_BITS  = 55;
   localparam int INDEX_BITS   = 3;
   localparam int FIELD_BITS   = 24;
   localparam int PRIO_FIELD   = 4;
   localparam int BYTE_BITS    = 8;

   // Access codes
   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   // Region kind codes
   localparam logic [1:0] KIND_RAM      = 2'd0;
   localparam logic [1:0] KIND_ROM      = 2'd1;
   localparam logic [1:0] KIND_MMIO     = 2'd2;
   localparam logic [1:0] KIND_MMIO_ALT = 2'd3;

   // One region register, packed to match the register bit layout
   typedef struct packed {
      logic                    enabled;     // [54]
      logic [1:0]              kind;        // [53:52]
      logic [PRIO_FIELD-1:0]   prio;        // [51:48]
      logic [FIELD_BITS-1:0]   last_addr;   // [47:24], inclusive
      logic [FIELD_BITS-1:0]   first_addr;  // [23:0]
   } region_type;

   typedef region_type [MAX_REGIONS-1:0] region_file_type;

   // Candidate winner in the selection tree
   typedef struct packed {
      logic                    found;
      logic [INDEX_BITS-1:0]   idx;
      logic [PRIO_FIELD-1:0]   prio;
   } cand_type;

   // Item after the compare stage
   typedef struct packed {
      logic                    action;
      logic [BYTE_BITS-1:0]    data;
      logic [FIELD_BITS-1:0]   addr;
      logic [MAX_REGIONS-1:0]  match;
   } match_type;

   // Item after the first selection stage
   typedef struct packed {
      logic                    action;
      logic [BYTE_BITS-1:0]    data;
      logic [FIELD_BITS-1:0]   addr;
      cand_type                cand_lo;
      cand_type                cand_hi;
   } select_type;

   // Result item
   typedef struct packed {
      logic                    hit;
      logic [INDEX_BITS-1:0]   region_index;
      logic [1:0]              region_kind;
      logic [FIELD_BITS-1:0]   offset;
      logic                    store_enable;
      logic [BYTE_BITS-1:0]    store_byte;
      logic                    open_bus;
      logic [FIELD_BITS-1:0]   masked_address;
   } rsp_type;

   // Pick the better of two candidates; a covers the lower region numbers,
   // so it keeps ties.
   function automatic cand_type pick_cand(input cand_type a, input cand_type b);
      cand_type r;
      if (!a.found) begin
         r = b;
      end else if (!b.found) begin
         r = a;
      end else if (b.prio > a.prio) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

### rtl/core/prad_match.sv
// ----------------------------------------------------------------------------
// prad_match: address mask and range compare stage
// Masks the raw address and compares it against every region in parallel;
// registers one match bit per region together with the item.
// ----------------------------------------------------------------------------
module prad_match #(
   parameter int ADDR_BITS   = prad_pkg::ADDR_BITS_DEFAULT,
   parameter int NUM_REGIONS = prad_pkg::NUM_REGIONS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic                              action,
   input  logic [31:0]                       address,
   input  logic [prad_pkg::BYTE_BITS-1:0]    write_data,
   input  logic [prad_pkg::MAX_REGIONS-1:0]  active_mask,
   input  prad_pkg::region_file_type         regions,
   output logic                              out_valid,
   output prad_pkg::match_type               out_item
);

   // Compare width: wide enough for the masked address and a 24-bit field
   localparam int CW = (ADDR_BITS > prad_pkg::FIELD_BITS) ? ADDR_BITS : prad_pkg::FIELD_BITS;

   logic [CW-1:0]                     addr_c;
   logic [prad_pkg::MAX_REGIONS-1:0]  match;
   logic                              valid_ff;
   prad_pkg::match_type               item_ff;
   prad_pkg::match_type               item_in;

   assign addr_c = CW'(address[ADDR_BITS-1:0]);

   always_comb begin
      for (int i = 0; i < prad_pkg::MAX_REGIONS; i++) begin
         match[i] = (i < NUM_REGIONS) && regions[i].enabled && active_mask[i] &&
                    (addr_c >= CW'(regions[i].first_addr)) &&
                    (addr_c <= CW'(regions[i].last_addr));
      end
   end

   always_comb begin
      item_in.action = action;
      item_in.data   = write_data;
      item_in.addr   = addr_c[prad_pkg::FIELD_BITS-1:0];
      item_in.match  = match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/core/prad_select.sv
// ----------------------------------------------------------------------------
// prad_select: first levels of the priority tree
// Reduces the per-region matches to two candidates, one from each half of
// the region file, and registers them with the item.
// ----------------------------------------------------------------------------
module prad_select #(
   parameter int PRIO_BITS = prad_pkg::PRIO_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  prad_pkg::match_type         in_item,
   input  prad_pkg::region_file_type   regions,
   output logic                        out_valid,
   output prad_pkg::select_type        out_item
);

   localparam int HALF    = prad_pkg::MAX_REGIONS / 2;
   localparam int QUARTER = prad_pkg::MAX_REGIONS / 4;
   localparam logic [prad_pkg::PRIO_FIELD-1:0] PRIO_MASK =
      prad_pkg::PRIO_FIELD'((1 << PRIO_BITS) - 1);

   prad_pkg::cand_type    leaf [prad_pkg::MAX_REGIONS];
   prad_pkg::cand_type    lvl1 [HALF];
   prad_pkg::cand_type    lvl2 [QUARTER];
   logic                  valid_ff;
   prad_pkg::select_type  item_ff;
   prad_pkg::select_type  item_in;

   always_comb begin
      for (int i = 0; i < prad_pkg::MAX_REGIONS; i++) begin
         leaf[i].found = in_item.match[i];
         leaf[i].idx   = prad_pkg::INDEX_BITS'(i);
         leaf[i].prio  = regions[i].prio & PRIO_MASK;
      end
      for (int j = 0; j < HALF; j++) begin
         lvl1[j] = prad_pkg::pick_cand(leaf[2*j], leaf[2*j+1]);
      end
      for (int k = 0; k < QUARTER; k++) begin
         lvl2[k] = prad_pkg::pick_cand(lvl1[2*k], lvl1[2*k+1]);
      end
   end

   always_comb begin
      item_in.action  = in_item.action;
      item_in.data    = in_item.data;
      item_in.addr    = in_item.addr;
      item_in.cand_lo = lvl2[0];
      item_in.cand_hi = lvl2[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/core/prad_resolve.sv
// ----------------------------------------------------------------------------
// prad_resolve: final pick and result register
// Picks the winner of the two candidates, looks up its kind and start,
// forms the offset and the store and open-bus flags, and holds the result.
// ----------------------------------------------------------------------------
module prad_resolve (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  prad_pkg::select_type        in_item,
   input  prad_pkg::region_file_type   regions,
   output logic                        out_valid,
   output prad_pkg::rsp_type           out_item
);

   prad_pkg::cand_type    win;
   prad_pkg::region_type  rg;
   logic [1:0]            kind;
   logic                  valid_ff;
   prad_pkg::rsp_type     item_ff;
   prad_pkg::rsp_type     item_in;

   always_comb begin
      win  = prad_pkg::pick_cand(in_item.cand_lo, in_item.cand_hi);
      rg   = regions[win.idx];
      // fold the spare kind code into MMIO
      kind = (rg.kind == prad_pkg::KIND_MMIO_ALT) ? prad_pkg::KIND_MMIO : rg.kind;

      item_in.hit            = win.found;
      item_in.region_index   = win.found ? win.idx : '0;
      item_in.region_kind    = win.found ? kind : prad_pkg::KIND_RAM;
      item_in.offset         = win.found ? (in_item.addr - rg.first_addr) : '0;
      item_in.store_enable   = win.found && (in_item.action == prad_pkg::ACT_WRITE) &&
                               (kind == prad_pkg::KIND_RAM);
      item_in.store_byte     = in_item.data;
      item_in.open_bus       = !win.found && (in_item.action == prad_pkg::ACT_READ);
      item_in.masked_address = in_item.addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/core/priority_region_address_decoder_unit.sv
// ----------------------------------------------------------------------------
// priority_region_address_decoder_unit: priority region address decoder
// Decodes byte bus accesses in eight address regions, one per unstalled cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one access item per valid/stall handshake:
//   read or write, raw address, write byte and a per-region active mask.
//   Response channel (rsp_*): one decode result per item, in order.
//   Configuration port (csr_*): write region register csr_index with
//   csr_write_data when csr_write_enable is high; only while no item is
//   in flight. Registers reset to zero, which disables every region.
//   An accepted item passes three registered stages to rsp_valid: range
//   compare, priority tree over region pairs and quads, final pick with
//   offset subtract into the result register. Throughput is one item
//   per cycle while rsp_stall is low. Each stage advances when it is empty
//   or the stage after it moves, so bubbles close up and req_stall rises
//   only when all three stages are full and rsp_stall is high. A stalled
//   result holds in the output register. Synchronous reset empties the
//   pipeline and clears the region registers.
// ----------------------------------------------------------------------------
module priority_region_address_decoder_unit #(
   parameter int ADDR_BITS   = prad_pkg::ADDR_BITS_DEFAULT,
   parameter int NUM_REGIONS = prad_pkg::NUM_REGIONS_DEFAULT,
   parameter int PRIO_BITS   = prad_pkg::PRIO_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [prad_pkg::INDEX_BITS-1:0]    csr_index,
   input  logic [prad_pkg::REGION_BITS-1:0]   csr_write_data,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [31:0]                        req_address,
   input  logic [prad_pkg::BYTE_BITS-1:0]     req_write_data,
   input  logic [prad_pkg::MAX_REGIONS-1:0]   req_active_mask,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [prad_pkg::INDEX_BITS-1:0]    rsp_region_index,
   output logic [1:0]                         rsp_region_kind,
   output logic [prad_pkg::FIELD_BITS-1:0]    rsp_offset,
   output logic                               rsp_store_enable,
   output logic [prad_pkg::BYTE_BITS-1:0]     rsp_store_byte,
   output logic                               rsp_open_bus,
   output logic [prad_pkg::FIELD_BITS-1:0]    rsp_masked_address
);

   // Region register file
   prad_pkg::region_file_type  regions_ff;

   // Stage handshake
   logic                  s1_valid;
   logic                  s2_valid;
   logic                  s3_valid;
   logic                  s1_advance;
   logic                  s2_advance;
   logic                  s3_advance;
   prad_pkg::match_type   s1_item;
   prad_pkg::select_type  s2_item;
   prad_pkg::rsp_type     s3_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         regions_ff <= '0;
      end else if (csr_write_enable) begin
         regions_ff[csr_index] <= prad_pkg::region_type'(csr_write_data);
      end
   end

   // Advance a stage when it is empty or its successor moves
   assign s3_advance = !s3_valid || !rsp_stall;
   assign s2_advance = !s2_valid || s3_advance;
   assign s1_advance = !s1_valid || s2_advance;
   assign req_stall  = !s1_advance;

   prad_match #(
      .ADDR_BITS   (ADDR_BITS),
      .NUM_REGIONS (NUM_REGIONS)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_advance),
      .in_valid    (req_valid),
      .action      (req_action),
      .address     (req_address),
      .write_data  (req_write_data),
      .active_mask (req_active_mask),
      .regions     (regions_ff),
      .out_valid   (s1_valid),
      .out_item    (s1_item)
   );

   prad_select #(
      .PRIO_BITS (PRIO_BITS)
   ) u_select (
      .clock     (clock),
      .reset     (reset),
      .advance   (s2_advance),
      .in_valid  (s1_valid),
      .in_item   (s1_item),
      .regions   (regions_ff),
      .out_valid (s2_valid),
      .out_item  (s2_item)
   );

   prad_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .advance   (s3_advance),
      .in_valid  (s2_valid),
      .in_item   (s2_item),
      .regions   (regions_ff),
      .out_valid (s3_valid),
      .out_item  (s3_item)
   );

   // Drive the response ports from the result register
   assign rsp_valid          = s3_valid;
   assign rsp_hit            = s3_item.hit;
   assign rsp_region_index   = s3_item.region_index;
   assign rsp_region_kind    = s3_item.region_kind;
   assign rsp_offset         = s3_item.offset;
   assign rsp_store_enable   = s3_item.store_enable;
   assign rsp_store_byte     = s3_item.store_byte;
   assign rsp_open_bus       = s3_item.open_bus;
   assign rsp_masked_address = s3_item.masked_address;

endmodule

### rtl/core/prad_checker.sv
// ----------------------------------------------------------------------------
// prad_checker: port-level checks of the priority region decoder
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module prad_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_stall,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_hit,
   input  logic [prad_pkg::INDEX_BITS-1:0]    rsp_region_index,
   input  logic [1:0]                         rsp_region_kind,
   input  logic [prad_pkg::FIELD_BITS-1:0]    rsp_offset,
   input  logic                               rsp_store_enable,
   input  logic                               rsp_open_bus,
   input  logic [prad_pkg::FIELD_BITS-1:0]    rsp_masked_address
);

   // Pipeline empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A miss reports zero winner fields and no store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_region_index == '0 && rsp_offset == '0 &&
          rsp_region_kind == prad_pkg::KIND_RAM && !rsp_store_enable))
      else $error("miss carries winner fields");

   // A store needs a RAM hit and never coincides with open bus
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_enable) |->
         (rsp_hit && rsp_region_kind == prad_pkg::KIND_RAM && !rsp_open_bus))
      else $error("store without a RAM hit");

   // Empty output register never pushes back on the request side
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !rsp_stall) |-> !req_stall)
      else $error("request stalled while output is free");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_masked_address) &&
                                    $stable(rsp_hit)))
      else $error("stalled response changed");

endmodule

bind priority_region_address_decoder_unit prad_checker u_prad_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_hit            (rsp_hit),
   .rsp_region_index   (rsp_region_index),
   .rsp_region_kind    (rsp_region_kind),
   .rsp_offset         (rsp_offset),
   .rsp_store_enable   (rsp_store_enable),
   .rsp_open_bus       (rsp_open_bus),
   .rsp_masked_address (rsp_masked_address)
);
